### src/bootloader_packet_framer_assert.svh
// assertion macros used by the checker file of the packet framer
// no dependencies; clock aclk and active-low reset aresetn must be in scope
`ifndef BOOTLOADER_PACKET_FRAMER_ASSERT_SVH
`define BOOTLOADER_PACKET_FRAMER_ASSERT_SVH

// same-cycle implication
`define BPF_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bpf_pkg.sv
// shared types, constants and the command length table of the packet framer
// no dependencies
package bpf_pkg;

    localparam int CNT_W          = 9;
    localparam int BYTE_W         = 8;
    localparam int IDLE_W         = 16;
    localparam int CHUNK_CAP_DEF  = 384;
    localparam int QUEUE_DEPTH    = 4;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [BYTE_W-1:0] CMD_SET_BUFFER = 8'hFE;
    localparam logic [BYTE_W-1:0] BUF_FULL_PAGE  = 8'h01;
    localparam logic [IDLE_W-1:0] IDLE_GAP_RST   = 16'd200;
    localparam logic [IDLE_W-1:0] IDLE_MAX       = 16'hFFFF;
    localparam logic [CNT_W-1:0]  PAGE_LEN       = 9'd256;
    localparam logic [CNT_W-1:0]  CRC_LEN        = 9'd2;
    localparam logic [CNT_W-1:0]  HDR_PAYLOAD_AT = 9'd4;

    typedef enum logic [1:0] {
        PH_WAITING,
        PH_COMMAND,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [0:0] {
        CFG_IDLE_GAP,
        CFG_LINK_READY
    } cfg_idx_t;

    typedef enum logic [0:0] {
        MODE_BYTE,
        MODE_TICK
    } mode_t;

    typedef enum logic [0:0] {
        KIND_APPEND,
        KIND_RELEASE
    } kind_t;

    typedef enum logic [1:0] {
        SLOT_PRE,
        SLOT_APP,
        SLOT_POST
    } slot_t;

    // all results caused by one input item
    typedef struct packed {
        logic              pre_vld;
        logic [CNT_W-1:0]  pre_len;
        logic              pre_pause;
        logic              pre_disc;
        logic              app_vld;
        logic [BYTE_W-1:0] app_byte;
        logic              post_vld;
        logic [CNT_W-1:0]  post_len;
        logic              post_pause;
        logic              post_disc;
    } bundle_t;

    function automatic logic [CNT_W-1:0] len_for(input logic [BYTE_W-1:0] cmd);
        logic [CNT_W-1:0] len;
        case (cmd)
            8'hFF, 8'hFE: len = 9'd6;
            8'h00:        len = 9'd21;
            8'h01, 8'h02, 8'h03, 8'h04,
            8'h05, 8'h06, 8'h07, 8'hFD: len = 9'd4;
            default:      len = 9'd1;
        endcase
        return len;
    endfunction

endpackage

### src/bpf_front.sv
// front end: config registers, framing state and classification of input items
// into result bundles; depends on bpf_pkg
module bpf_front #(
    parameter int CHUNK_CAPACITY = bpf_pkg::CHUNK_CAP_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        in_mode,
    input  logic [bpf_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_addr,
    input  logic [bpf_pkg::IDLE_W-1:0]  cfg_wdata,
    input  logic                        q_full,
    output logic                        q_push,
    output bpf_pkg::bundle_t            q_entry
);

    localparam logic [bpf_pkg::CNT_W-1:0] CAP = bpf_pkg::CNT_W'(CHUNK_CAPACITY);

    bpf_pkg::phase_t                phase_reg, phase_next;
    logic [bpf_pkg::CNT_W-1:0]      pend_reg, pend_next;
    logic [bpf_pkg::CNT_W-1:0]      exp_reg, exp_next;
    logic [bpf_pkg::BYTE_W-1:0]     first_reg, first_next;
    logic [bpf_pkg::BYTE_W-1:0]     third_reg, third_next;
    logic [bpf_pkg::BYTE_W-1:0]     fourth_reg, fourth_next;
    logic                           pause_reg, pause_next;
    logic                           timer_reg, timer_next;
    logic [bpf_pkg::IDLE_W-1:0]     idle_reg, idle_next;
    logic [bpf_pkg::IDLE_W-1:0]     gap_reg;
    logic                           link_reg;

    logic                           accept;
    logic                           pre;
    logic [bpf_pkg::CNT_W-1:0]      pc_e, pc_n, exp_e, payload;
    logic                           pause_e, enter_cmd;
    bpf_pkg::phase_t                phase_e;
    logic [bpf_pkg::BYTE_W-1:0]     first_e, third_e, fourth_e;
    logic [bpf_pkg::IDLE_W-1:0]     idle_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg  <= bpf_pkg::IDLE_GAP_RST;
            link_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (bpf_pkg::cfg_idx_t'(cfg_addr))
                bpf_pkg::CFG_IDLE_GAP:   gap_reg  <= cfg_wdata;
                bpf_pkg::CFG_LINK_READY: link_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= bpf_pkg::PH_WAITING;
            pend_reg   <= '0;
            exp_reg    <= '0;
            first_reg  <= '0;
            third_reg  <= '0;
            fourth_reg <= '0;
            pause_reg  <= 1'b0;
            timer_reg  <= 1'b0;
            idle_reg   <= '0;
        end else begin
            phase_reg  <= phase_next;
            pend_reg   <= pend_next;
            exp_reg    <= exp_next;
            first_reg  <= first_next;
            third_reg  <= third_next;
            fourth_reg <= fourth_next;
            pause_reg  <= pause_next;
            timer_reg  <= timer_next;
            idle_reg   <= idle_next;
        end
    end

    always_comb begin
        // release ahead of a byte: idle timeout or full chunk
        pre       = (timer_reg && (idle_reg >= gap_reg)) || (pend_reg >= CAP);
        enter_cmd = pre || (phase_reg == bpf_pkg::PH_WAITING);
        pc_e      = pre ? '0 : pend_reg;
        pause_e   = pre ? 1'b0 : pause_reg;
        phase_e   = enter_cmd ? bpf_pkg::PH_COMMAND : phase_reg;
        exp_e     = enter_cmd ? bpf_pkg::len_for(in_byte) : exp_reg;
        first_e   = (pc_e == 9'd0) ? in_byte : first_reg;
        third_e   = (pc_e == 9'd2) ? in_byte : third_reg;
        fourth_e  = (pc_e == 9'd3) ? in_byte : fourth_reg;
        pc_n      = pc_e + 9'd1;
        payload   = '0;
        if (first_e == bpf_pkg::CMD_SET_BUFFER && pc_n >= bpf_pkg::HDR_PAYLOAD_AT) begin
            payload = (third_e == bpf_pkg::BUF_FULL_PAGE) ? bpf_pkg::PAGE_LEN
                                                          : {1'b0, fourth_e};
        end
        idle_inc = (idle_reg == bpf_pkg::IDLE_MAX) ? idle_reg : idle_reg + 16'd1;

        phase_next  = phase_reg;
        pend_next   = pend_reg;
        exp_next    = exp_reg;
        first_next  = first_reg;
        third_next  = third_reg;
        fourth_next = fourth_reg;
        pause_next  = pause_reg;
        timer_next  = timer_reg;
        idle_next   = idle_reg;
        q_push      = 1'b0;
        q_entry     = '0;

        if (accept) begin
            unique case (bpf_pkg::mode_t'(in_mode))
                bpf_pkg::MODE_TICK: begin
                    if (timer_reg) begin
                        idle_next = idle_inc;
                        if (idle_inc >= gap_reg) begin
                            q_entry.pre_vld   = 1'b1;
                            q_entry.pre_len   = pend_reg;
                            q_entry.pre_pause = pause_reg;
                            q_entry.pre_disc  = !link_reg;
                            q_push            = (pend_reg != 9'd0);
                            phase_next = bpf_pkg::PH_WAITING;
                            pend_next  = '0;
                            exp_next   = '0;
                            timer_next = 1'b0;
                            idle_next  = '0;
                            pause_next = 1'b0;
                        end
                    end
                end
                bpf_pkg::MODE_BYTE: begin
                    q_push            = 1'b1;
                    q_entry.pre_vld   = pre && (pend_reg != 9'd0);
                    q_entry.pre_len   = pend_reg;
                    q_entry.pre_pause = pause_reg;
                    q_entry.pre_disc  = !link_reg;
                    q_entry.app_vld   = 1'b1;
                    q_entry.app_byte  = in_byte;
                    first_next  = first_e;
                    third_next  = third_e;
                    fourth_next = fourth_e;
                    timer_next  = 1'b1;
                    idle_next   = '0;
                    if (pc_n >= exp_e) begin
                        q_entry.post_vld   = 1'b1;
                        q_entry.post_len   = pc_n;
                        q_entry.post_pause = pause_e;
                        q_entry.post_disc  = !link_reg;
                        pend_next = '0;
                        if (phase_e == bpf_pkg::PH_COMMAND
                            && first_e == bpf_pkg::CMD_SET_BUFFER) begin
                            phase_next = bpf_pkg::PH_PAYLOAD;
                            exp_next   = payload + bpf_pkg::CRC_LEN;
                            pause_next = 1'b1;
                        end else begin
                            phase_next = bpf_pkg::PH_WAITING;
                            exp_next   = '0;
                            pause_next = 1'b0;
                            timer_next = 1'b0;
                        end
                    end else begin
                        phase_next = phase_e;
                        pend_next  = pc_n;
                        exp_next   = exp_e;
                        pause_next = pause_e;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### src/bpf_queue.sv
// short queue of result bundles between the front end and the output sequencer
// depends on bpf_pkg
module bpf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  bpf_pkg::bundle_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bpf_pkg::bundle_t  head_entry
);

    localparam int DEPTH = bpf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bpf_pkg::bundle_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

endmodule

### src/bpf_back.sv
// back end: walks the queued bundles slot by slot into the registered output
// depends on bpf_pkg
module bpf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  bpf_pkg::bundle_t              head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output logic [bpf_pkg::BYTE_W-1:0]    out_byte,
    output logic [bpf_pkg::CNT_W-1:0]     out_len,
    output logic                          out_pause,
    output logic                          out_disc,
    output logic                          out_last
);

    bpf_pkg::slot_t             step_reg, step_next;
    logic                       valid_reg, valid_next;
    logic                       kind_reg, kind_next;
    logic [bpf_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic [bpf_pkg::CNT_W-1:0]  len_reg, len_next;
    logic                       pause_reg, pause_next;
    logic                       disc_reg, disc_next;
    logic                       last_reg, last_next;
    logic                       load, use_pre, use_app, sel_last;

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_byte  = byte_reg;
    assign out_len   = len_reg;
    assign out_pause = pause_reg;
    assign out_disc  = disc_reg;
    assign out_last  = last_reg;

    always_comb begin
        load    = head_valid && (!valid_reg || out_ready);
        use_pre = (step_reg == bpf_pkg::SLOT_PRE) && head_entry.pre_vld;
        use_app = !use_pre && (step_reg != bpf_pkg::SLOT_POST) && head_entry.app_vld;
        if (use_pre) begin
            sel_last = !head_entry.app_vld && !head_entry.post_vld;
        end else if (use_app) begin
            sel_last = !head_entry.post_vld;
        end else begin
            sel_last = 1'b1;
        end
        pop = load && sel_last;

        step_next  = step_reg;
        valid_next = valid_reg && !out_ready;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        len_next   = len_reg;
        pause_next = pause_reg;
        disc_next  = disc_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            last_next  = sel_last;
            if (use_pre) begin
                kind_next  = bpf_pkg::KIND_RELEASE;
                byte_next  = '0;
                len_next   = head_entry.pre_len;
                pause_next = head_entry.pre_pause;
                disc_next  = head_entry.pre_disc;
                step_next  = bpf_pkg::SLOT_APP;
            end else if (use_app) begin
                kind_next  = bpf_pkg::KIND_APPEND;
                byte_next  = head_entry.app_byte;
                len_next   = '0;
                pause_next = 1'b0;
                disc_next  = 1'b0;
                step_next  = bpf_pkg::SLOT_POST;
            end else begin
                kind_next  = bpf_pkg::KIND_RELEASE;
                byte_next  = '0;
                len_next   = head_entry.post_len;
                pause_next = head_entry.post_pause;
                disc_next  = head_entry.post_disc;
            end
            if (sel_last) begin
                step_next = bpf_pkg::SLOT_PRE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= bpf_pkg::SLOT_PRE;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        len_reg   <= len_next;
        pause_reg <= pause_next;
        disc_reg  <= disc_next;
        last_reg  <= last_next;
    end

endmodule

### src/bootloader_packet_framer.sv
// channel     | dir | handshake              | payload
// s_axis      | in  | s_axis_tvalid/tready   | tuser: mode, tdata: data_in
// m_axis      | out | m_axis_tvalid/tready   | tuser: kind, tdata: result fields, tlast
// cfg         | in  | cfg_we (no wait)       | cfg_addr: register index, cfg_wdata
//
// an input item is taken every cycle while the four-entry bundle queue has room
// a byte yields one to three results, a tick zero or one; results leave one per
// cycle from the output register, so the output port sets the sustained rate
// each result passes through the bundle queue and then the output register before it shows
// reset is synchronous and needs no clearing pass; either side may stall freely
// top level of the packet framer; depends on bpf_pkg, bpf_front, bpf_queue, bpf_back
module bootloader_packet_framer #(
    parameter int CHUNK_CAPACITY = bpf_pkg::CHUNK_CAP_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bpf_pkg::BYTE_W-1:0]        s_axis_tdata,  // [7:0] data_in
    input  logic                              s_axis_tuser,  // [0] mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] data_out, [16:8] chunk_length, [17] pause_first, [18] discard, rest zero
    output logic [bpf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,  // [0] kind
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_addr,
    input  logic [bpf_pkg::IDLE_W-1:0]        cfg_wdata
);

    localparam int PAD_W = bpf_pkg::OUT_TDATA_W - bpf_pkg::BYTE_W - bpf_pkg::CNT_W - 2;

    logic                       q_full, q_push, q_pop, q_head_valid;
    bpf_pkg::bundle_t           q_entry, q_head;
    logic [bpf_pkg::BYTE_W-1:0] out_byte;
    logic [bpf_pkg::CNT_W-1:0]  out_len;
    logic                       out_pause, out_disc;

    bpf_front #(
        .CHUNK_CAPACITY (CHUNK_CAPACITY)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    bpf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    bpf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_byte   (out_byte),
        .out_len    (out_len),
        .out_pause  (out_pause),
        .out_disc   (out_disc),
        .out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, out_disc, out_pause, out_len, out_byte};

endmodule

### src/bpf_checker.sv
// port-level checks on the packet framer's result channel, bound to the top level
// depends on bpf_pkg and bootloader_packet_framer_assert.svh
`include "bootloader_packet_framer_assert.svh"

module bpf_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    `BPF_ASSERT_NEXT(a_valid_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `BPF_ASSERT_NEXT(a_payload_holds, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")
    `BPF_ASSERT_IMPLIES(a_release_shape, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[16:8] != 9'd0) && (m_axis_tdata[7:0] == 8'd0), "release with empty length or stray byte")
    `BPF_ASSERT_IMPLIES(a_append_shape, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[23:8] == 16'd0, "append item carries release fields")

endmodule

bind bootloader_packet_framer bpf_checker u_bpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/tb_bootloader_packet_framer.sv
// testbench for the bootloader packet framer: drives bytes and ticks with random gaps
// and checks every result against a framing tracker class; depends on bpf_pkg and the RTL
module tb_bootloader_packet_framer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT   = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PRESS_ITEMS   = 16;

    localparam logic [7:0] CMD_HEAD6    = 8'hFF;
    localparam logic [7:0] CMD_LONG     = 8'h00;
    localparam logic [7:0] CMD_SHORT_LO = 8'h01;
    localparam logic [7:0] CMD_SHORT_HI = 8'h07;
    localparam logic [7:0] CMD_SHORT_FD = 8'hFD;

    typedef struct {
        bpf_pkg::kind_t kind;
        logic [7:0]     data;
        logic [8:0]     len;
        logic           pause;
        logic           disc;
        logic           is_last;
    } framer_result_t;

    function automatic int packet_length(input logic [7:0] c);
        if (c == CMD_HEAD6 || c == bpf_pkg::CMD_SET_BUFFER) return 6;
        if (c == CMD_LONG) return 21;
        if ((c >= CMD_SHORT_LO && c <= CMD_SHORT_HI) || c == CMD_SHORT_FD) return 4;
        return 1;
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    class packet_framing;
        logic [15:0]      idle_gap;
        logic             link_up;
        bpf_pkg::phase_t  ph;
        logic [8:0]       pend_cnt;
        logic [8:0]       want_cnt;
        logic [7:0]       cmd_byte;
        logic [7:0]       byte3;
        logic [7:0]       byte4;
        logic             pause_pend;
        logic             timer_on;
        logic [15:0]      idle_cnt;
        framer_result_t   due_results[$];
        framer_result_t   step_q[$];
        int               errors;

        function new();
            idle_gap   = bpf_pkg::IDLE_GAP_RST;
            link_up    = 1'b0;
            ph         = bpf_pkg::PH_WAITING;
            pend_cnt   = '0;
            want_cnt   = '0;
            cmd_byte   = '0;
            byte3      = '0;
            byte4      = '0;
            pause_pend = 1'b0;
            timer_on   = 1'b0;
            idle_cnt   = '0;
            errors     = 0;
        endfunction

        function void write_reg(bpf_pkg::cfg_idx_t idx, logic [15:0] v);
            if (idx == bpf_pkg::CFG_IDLE_GAP) begin
                idle_gap = v;
            end else begin
                link_up = v[0];
            end
        endfunction

        // an empty chunk gives no release item
        function void flush_chunk();
            framer_result_t r;
            if (pend_cnt == 0) return;
            r = '{kind: bpf_pkg::KIND_RELEASE, data: 8'd0, len: pend_cnt,
                  pause: pause_pend, disc: !link_up, is_last: 1'b0};
            step_q.push_back(r);
            pend_cnt   = '0;
            pause_pend = 1'b0;
        endfunction

        function void restart(bit do_flush);
            if (do_flush) flush_chunk();
            ph         = bpf_pkg::PH_WAITING;
            pend_cnt   = '0;
            want_cnt   = '0;
            timer_on   = 1'b0;
            idle_cnt   = '0;
            pause_pend = 1'b0;
        endfunction

        function void take_item(bpf_pkg::mode_t m, logic [7:0] b);
            framer_result_t r;
            logic [8:0]     payload;
            step_q.delete();
            if (m == bpf_pkg::MODE_TICK) begin
                if (timer_on) begin
                    if (idle_cnt != bpf_pkg::IDLE_MAX) idle_cnt++;
                    if (idle_cnt >= idle_gap) restart(1'b1);
                end
            end else begin
                if (timer_on && idle_cnt >= idle_gap) restart(1'b1);
                timer_on = 1'b1;
                idle_cnt = '0;
                if (ph == bpf_pkg::PH_WAITING) begin
                    ph       = bpf_pkg::PH_COMMAND;
                    want_cnt = 9'(packet_length(b));
                end
                if (pend_cnt >= bpf_pkg::CHUNK_CAP_DEF) begin
                    restart(1'b1);
                    ph       = bpf_pkg::PH_COMMAND;
                    want_cnt = 9'(packet_length(b));
                    timer_on = 1'b1;
                    idle_cnt = '0;
                end
                case (pend_cnt)
                    0: cmd_byte = b;
                    2: byte3 = b;
                    3: byte4 = b;
                    default: ;
                endcase
                pend_cnt++;
                r = '{kind: bpf_pkg::KIND_APPEND, data: b, len: 9'd0, pause: 1'b0,
                      disc: 1'b0, is_last: 1'b0};
                step_q.push_back(r);
                if (pend_cnt >= want_cnt) begin
                    if (ph == bpf_pkg::PH_COMMAND) begin
                        payload = '0;
                        if (cmd_byte == bpf_pkg::CMD_SET_BUFFER
                            && pend_cnt >= bpf_pkg::HDR_PAYLOAD_AT)
                            payload = (byte3 == bpf_pkg::BUF_FULL_PAGE) ? bpf_pkg::PAGE_LEN
                                                                        : {1'b0, byte4};
                        flush_chunk();
                        if (cmd_byte == bpf_pkg::CMD_SET_BUFFER) begin
                            // header done, payload plus crc follows after a pause
                            ph         = bpf_pkg::PH_PAYLOAD;
                            want_cnt   = payload + bpf_pkg::CRC_LEN;
                            pause_pend = 1'b1;
                            timer_on   = 1'b1;
                            idle_cnt   = '0;
                        end else begin
                            restart(1'b0);
                        end
                    end else begin
                        restart(1'b1);
                    end
                end
            end
            if (step_q.size() > 0) step_q[$].is_last = 1'b1;
            foreach (step_q[i]) due_results.push_back(step_q[i]);
        endfunction

        function void cmp(string what, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(bpf_pkg::kind_t k, logic [bpf_pkg::OUT_TDATA_W-1:0] td,
                                   logic lst);
            framer_result_t e;
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, got kind %0d tdata %h last %0b",
                         $time, k, td, lst);
                errors++;
                return;
            end
            e = due_results.pop_front();
            cmp("kind", e.kind, k);
            cmp("data_out", e.data, td[7:0]);
            cmp("chunk_length", e.len, td[16:8]);
            cmp("pause_first", e.pause, td[17]);
            cmp("discard", e.disc, td[18]);
            cmp("tdata pad", 0, td[bpf_pkg::OUT_TDATA_W-1:19]);
            cmp("last", e.is_last, lst);
        endfunction
    endclass

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [bpf_pkg::BYTE_W-1:0]      s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [bpf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            cfg_we = 1'b0;
    logic [0:0]                      cfg_addr = '0;
    logic [bpf_pkg::IDLE_W-1:0]      cfg_wdata = '0;

    packet_framing framing;
    bit            idle_on = 1'b1;
    bit            hold_req = 1'b0;
    int            cur_gap = int'(bpf_pkg::IDLE_GAP_RST);
    int            n_bytes = 0;
    int            quiet_cycles = 0;

    bootloader_packet_framer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL bootloader_packet_framer");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int wait_n;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            wait_n = idle_on ? $urandom_range(0, 8) : 0;
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (m_axis_tvalid !== 1'b1);
            framing.check_result(bpf_pkg::kind_t'(m_axis_tuser), m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic send_item(input bpf_pkg::mode_t m, input logic [7:0] d);
        int wait_n;
        wait_n = idle_on ? $urandom_range(0, 8) : 0;
        if (wait_n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (wait_n) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= m;
        s_axis_tdata  <= d;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        framing.take_item(m, d);
        if (m == bpf_pkg::MODE_BYTE) n_bytes++;
    endtask

    // registers change only once the framer has gone quiet
    task automatic write_regs(input logic [15:0] gap, input logic link);
        s_axis_tvalid <= 1'b0;
        while (framing.due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= bpf_pkg::CFG_IDLE_GAP;
        cfg_wdata <= gap;
        @(posedge aclk);
        framing.write_reg(bpf_pkg::CFG_IDLE_GAP, gap);
        cfg_addr  <= bpf_pkg::CFG_LINK_READY;
        cfg_wdata <= {15'd0, link};
        @(posedge aclk);
        framing.write_reg(bpf_pkg::CFG_LINK_READY, {15'd0, link});
        cfg_we <= 1'b0;
        cur_gap = int'(gap);
    endtask

    // one well-formed packet with random content, a stray tick now and then
    task automatic send_packet();
        logic [7:0] cmd;
        logic [7:0] third;
        logic [7:0] fourth;
        logic [7:0] d;
        int         total;
        case ($urandom_range(0, 5))
            0: cmd = CMD_HEAD6;
            1: cmd = bpf_pkg::CMD_SET_BUFFER;
            2: cmd = CMD_LONG;
            3: cmd = 8'($urandom_range(CMD_SHORT_LO, CMD_SHORT_HI));
            4: cmd = CMD_SHORT_FD;
            default: cmd = rand_byte();
        endcase
        third = rand_byte();
        if (third == bpf_pkg::BUF_FULL_PAGE) third = 8'h02;
        fourth = 8'($urandom_range(0, 15));
        total = packet_length(cmd);
        if (cmd == bpf_pkg::CMD_SET_BUFFER)
            total += int'(fourth) + int'(bpf_pkg::CRC_LEN);
        for (int i = 0; i < total; i++) begin
            case (i)
                0: d = cmd;
                2: d = third;
                3: d = fourth;
                default: d = rand_byte();
            endcase
            send_item(bpf_pkg::MODE_BYTE, d);
            if ($urandom_range(0, 9) == 0) send_item(bpf_pkg::MODE_TICK, rand_byte());
        end
    endtask

    task automatic random_phase(input int target);
        int base;
        base = n_bytes;
        while (n_bytes - base < target) begin
            case ($urandom_range(0, 9))
                7: send_item(bpf_pkg::MODE_BYTE, rand_byte());
                8: repeat (cur_gap <= 12 ? cur_gap : $urandom_range(1, 4))
                       send_item(bpf_pkg::MODE_TICK, rand_byte());
                9: begin
                    // truncated packet, left to time out when the gap is short
                    send_item(bpf_pkg::MODE_BYTE, $urandom_range(0, 1) ? CMD_LONG : CMD_HEAD6);
                    repeat ($urandom_range(1, 3)) send_item(bpf_pkg::MODE_BYTE, rand_byte());
                    if (cur_gap <= 12)
                        repeat (cur_gap) send_item(bpf_pkg::MODE_TICK, rand_byte());
                end
                default: send_packet();
            endcase
        end
    endtask

    initial begin
        logic [15:0] gap_sel;
        framing = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: stand-alone byte, ignored tick, short packet
        send_item(bpf_pkg::MODE_BYTE, 8'h42);
        send_item(bpf_pkg::MODE_TICK, 8'hFF);
        send_item(bpf_pkg::MODE_BYTE, CMD_SHORT_LO);
        send_item(bpf_pkg::MODE_BYTE, 8'h80);
        send_item(bpf_pkg::MODE_BYTE, 8'h7F);
        send_item(bpf_pkg::MODE_BYTE, 8'hFF);
        // set-buffer header with empty payload, only the crc follows
        send_item(bpf_pkg::MODE_BYTE, bpf_pkg::CMD_SET_BUFFER);
        send_item(bpf_pkg::MODE_BYTE, 8'hA5);
        send_item(bpf_pkg::MODE_BYTE, 8'h00);
        send_item(bpf_pkg::MODE_BYTE, 8'h00);
        send_item(bpf_pkg::MODE_BYTE, 8'h5A);
        send_item(bpf_pkg::MODE_BYTE, 8'h3C);
        send_item(bpf_pkg::MODE_TICK, 8'h00);
        send_item(bpf_pkg::MODE_BYTE, 8'hFF);
        send_item(bpf_pkg::MODE_BYTE, 8'h00);
        // long packet left unfinished, then released by idle ticks
        send_item(bpf_pkg::MODE_BYTE, CMD_LONG);
        send_item(bpf_pkg::MODE_BYTE, 8'h01);
        send_item(bpf_pkg::MODE_BYTE, 8'h02);
        send_item(bpf_pkg::MODE_BYTE, 8'h03);
        write_regs(16'd3, 1'b0);
        repeat (3) send_item(bpf_pkg::MODE_TICK, 8'hAA);
        // gap lowered under a running timer: next byte releases first
        send_item(bpf_pkg::MODE_BYTE, CMD_SHORT_FD);
        repeat (2) send_item(bpf_pkg::MODE_TICK, 8'h55);
        write_regs(16'd1, 1'b1);
        send_item(bpf_pkg::MODE_BYTE, 8'h10);

        // full-page header, payload cut short and released by idle ticks
        write_regs(16'd3, 1'b1);
        send_item(bpf_pkg::MODE_BYTE, bpf_pkg::CMD_SET_BUFFER);
        send_item(bpf_pkg::MODE_BYTE, 8'h11);
        send_item(bpf_pkg::MODE_BYTE, bpf_pkg::BUF_FULL_PAGE);
        send_item(bpf_pkg::MODE_BYTE, 8'h00);
        send_item(bpf_pkg::MODE_BYTE, 8'h22);
        send_item(bpf_pkg::MODE_BYTE, 8'h33);
        repeat (3) send_item(bpf_pkg::MODE_BYTE, rand_byte());
        repeat (3) send_item(bpf_pkg::MODE_TICK, 8'h00);

        for (int p = 0; p < 5; p++) begin
            idle_on = (p != 2);
            case ($urandom_range(0, 5))
                0: gap_sel = 16'd1;
                1: gap_sel = 16'd2;
                2: gap_sel = 16'($urandom_range(3, 8));
                3: gap_sel = bpf_pkg::IDLE_GAP_RST;
                4: gap_sel = bpf_pkg::IDLE_MAX;
                default: gap_sel = 16'($urandom_range(1, 65535));
            endcase
            write_regs(gap_sel, 1'($urandom_range(0, 1)));
            random_phase(4);
        end

        // receiver holds off while the sender keeps offering items
        write_regs(bpf_pkg::IDLE_MAX, 1'b1);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (PRESS_ITEMS) send_item(bpf_pkg::MODE_BYTE, rand_byte());
        idle_on = 1'b1;

        write_regs(16'd1, 1'b0);
        random_phase(4);

        s_axis_tvalid <= 1'b0;
        while (framing.due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (framing.errors == 0) begin
            $display("PASS bootloader_packet_framer");
        end else begin
            $display("FAIL bootloader_packet_framer");
        end
        $finish;
    end

endmodule
